// ===== rtl/plsu_pkg.sv =====
// Shared types and constants for the positional list store unit.
// Holds request/response structs, op and status codes, and cell command type.
// No dependencies.
`default_nettype none
package plsu_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_READ   = 2'd2,
		REQ_SEARCH = 2'd3
	} plsu_req_type_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_FULL     = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_NOTFOUND = 3'd4
	} plsu_status_t;

	typedef enum logic [1:0] {
		SH_NONE,
		SH_INS,
		SH_REM
	} plsu_shift_t;

	typedef struct packed {
		plsu_req_type_t     req_type;
		logic signed [7:0]  position;
		logic signed [31:0] data_in;
	} plsu_req_t;

	typedef struct packed {
		plsu_status_t       status;
		logic signed [31:0] data_out;
		logic [5:0]         found_index;
		logic [6:0]         entry_count;
	} plsu_rsp_t;

	// Broadcast to every cell in the row.
	typedef struct packed {
		plsu_shift_t         op;
		logic [IDX_W-1:0]    at;
		logic [CNT_W-1:0]    cnt;
		logic [DATA_W-1:0]   wdata;
		logic                rd_en;
		logic [IDX_W-1:0]    rd_at;
	} plsu_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/plsu_cell.sv =====
// One storage cell of the list row: holds an entry, shifts with its neighbors.
// Depends on plsu_pkg.
`default_nettype none
module plsu_cell
	import plsu_pkg::*;
(
	input  wire logic              clk,
	input  wire logic [IDX_W-1:0]  idx,
	input  wire plsu_cmd_t         cmd,
	input  wire logic [DATA_W-1:0] left,
	input  wire logic [DATA_W-1:0] right,
	output logic      [DATA_W-1:0] data,
	output logic                   hit,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] entry_q;
	logic [CNT_W-1:0]  idx_c;
	logic [CNT_W:0]    idx_p1;
	logic              live;

	assign idx_c  = CNT_W'(idx);
	assign idx_p1 = {1'b0, idx_c} + 1'b1;
	assign live   = idx_c < cmd.cnt;
	assign data   = entry_q;
	assign hit    = live && (entry_q == cmd.wdata);
	assign rdata  = (cmd.rd_en && idx == cmd.rd_at) ? entry_q : '0;

	always_ff @(posedge clk) begin
		case (cmd.op)
			SH_INS: begin
				// load at the insert point, take from the left behind it
				if (idx == cmd.at)
					entry_q <= cmd.wdata;
				else if (idx > cmd.at && idx_c <= cmd.cnt)
					entry_q <= left;
			end
			SH_REM: begin
				// close the gap: take from the right from the removal point on
				if (idx >= cmd.at && idx_p1 < {1'b0, cmd.cnt})
					entry_q <= right;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/plsu_reduce.sv =====
// Collects the row outputs: first search hit and the selected read word.
// Depends on plsu_pkg.
`default_nettype none
module plsu_reduce
	import plsu_pkg::*;
(
	input  wire logic [CAPACITY-1:0] hits,
	input  wire logic [DATA_W-1:0]   rdata [CAPACITY],
	output logic                     found,
	output logic      [IDX_W-1:0]    found_idx,
	output logic      [DATA_W-1:0]   rword
);

	always_comb begin
		found     = |hits;
		found_idx = '0;
		// lowest index wins
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (hits[i])
				found_idx = IDX_W'(i);
		end
	end

	always_comb begin
		rword = '0;
		for (int i = 0; i < CAPACITY; i++)
			rword = rword | rdata[i];
	end

endmodule
`default_nettype wire

// ===== rtl/positional_list_store_unit.sv =====
// Positional list store unit: ordered list of up to CAPACITY signed words.
// Top level: request decode, row of plsu_cell, plsu_reduce, result register.
// Depends on plsu_pkg, plsu_cell, plsu_reduce.
//
// Usage:
//   Requests enter on req (req_valid / req_stall), results leave on rsp
//   (rsp_valid / rsp_stall). Each request yields exactly one result.
//   The list lives in a row of cells; insert and remove shift the cells behind
//   the addressed position at once away from or toward it, and search compares all
//   cells in parallel, so a request completes in the cycle it is accepted.
//   The result is registered: rsp_valid rises in the cycle after acceptance.
//   Throughput: one request per cycle while results are taken; the result
//   register is the only slot, so req_stall rises while a result is held
//   stalled and drops in the cycle the receiver takes it.
//   Reset clears the entry count and the result valid; cell contents are
//   left as they are and never read before being written.
`default_nettype none
module positional_list_store_unit
	import plsu_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire plsu_req_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output plsu_rsp_t      rsp
);

	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	plsu_rsp_t        rsp_q;

	logic             accept;
	plsu_cmd_t        cmd;
	logic [CNT_W-1:0] count_nxt;
	plsu_rsp_t        rsp_nxt;

	logic [DATA_W-1:0]   cell_data [CAPACITY];
	logic [DATA_W-1:0]   cell_rdata [CAPACITY];
	logic [CAPACITY-1:0] cell_hit;
	logic                found;
	logic [IDX_W-1:0]    found_idx;
	logic [DATA_W-1:0]   rword;

	// position decode
	logic             pos_m1;
	logic             pos_bad;
	logic [7:0]       pos_u;
	logic [7:0]       cnt_u;
	logic             pos_past;
	logic             full;
	logic             empty;
	logic [IDX_W-1:0] last_idx;

	assign accept    = req_valid && !req_stall;
	assign req_stall = rsp_valid_q && rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign pos_m1   = req.position == -8'sd1;
	assign pos_bad  = req.position[7] && !pos_m1;
	assign pos_u    = {1'b0, req.position[6:0]};
	assign cnt_u    = 8'(count_q);
	assign pos_past = pos_u >= cnt_u;
	assign full     = count_q == CNT_W'(CAPACITY);
	assign empty    = count_q == '0;
	assign last_idx = IDX_W'(count_q - 1'b1);

	// row command and next count
	always_comb begin
		cmd       = '0;
		cmd.op    = SH_NONE;
		cmd.cnt   = count_q;
		cmd.wdata = req.data_in;
		count_nxt = count_q;
		case (req.req_type)
			REQ_INSERT: begin
				if (!full && !pos_bad) begin
					cmd.op    = accept ? SH_INS : SH_NONE;
					cmd.at    = (pos_m1 || pos_past) ? IDX_W'(count_q) : IDX_W'(pos_u);
					count_nxt = count_q + 1'b1;
				end
			end
			REQ_REMOVE: begin
				if (!empty && !pos_bad) begin
					cmd.op    = accept ? SH_REM : SH_NONE;
					cmd.at    = (pos_m1 || pos_past) ? last_idx : IDX_W'(pos_u);
					cmd.rd_en = 1'b1;
					cmd.rd_at = cmd.at;
					count_nxt = count_q - 1'b1;
				end
			end
			REQ_READ: begin
				if (!empty && (pos_m1 || (!req.position[7] && !pos_past))) begin
					cmd.rd_en = 1'b1;
					cmd.rd_at = pos_m1 ? last_idx : IDX_W'(pos_u);
				end
			end
			default: begin
				// search: the row compares against wdata on its own
			end
		endcase
	end

	// result word
	always_comb begin
		rsp_nxt        = '0;
		rsp_nxt.status = ST_OK;
		case (req.req_type)
			REQ_INSERT: begin
				if (full)
					rsp_nxt.status = ST_FULL;
				else if (pos_bad)
					rsp_nxt.status = ST_BADPOS;
			end
			REQ_REMOVE: begin
				if (empty)
					rsp_nxt.status = ST_EMPTY;
				else if (pos_bad)
					rsp_nxt.status = ST_BADPOS;
				else
					rsp_nxt.data_out = rword;
			end
			REQ_READ: begin
				if (empty)
					rsp_nxt.status = ST_EMPTY;
				else if (pos_m1 || (!req.position[7] && !pos_past))
					rsp_nxt.data_out = rword;
				else
					rsp_nxt.status = ST_BADPOS;
			end
			default: begin
				// search: position is ignored
				if (found)
					rsp_nxt.found_index = 6'(found_idx);
				else
					rsp_nxt.status = ST_NOTFOUND;
			end
		endcase
		rsp_nxt.entry_count = 7'(count_nxt);
	end

	// row of cells; each hands its word to both neighbors
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;

		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[g+1];
		end

		plsu_cell u_cell (
			.clk   (clk),
			.idx   (IDX_W'(g)),
			.cmd   (cmd),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[g]),
			.hit   (cell_hit[g]),
			.rdata (cell_rdata[g])
		);
	end

	plsu_reduce u_reduce (
		.hits      (cell_hit),
		.rdata     (cell_rdata),
		.found     (found),
		.found_idx (found_idx),
		.rword     (rword)
	);

	// advance count on accepted requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_nxt;
		end
	end

	// result slot: load on accept, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			rsp_q <= rsp_nxt;
	end

endmodule
`default_nettype wire

// ===== tb/list_store_checker.sv =====
`timescale 1ns / 100ps
// Checker for the positional list store unit: watches the request and result
// channels, keeps its own copy of the list and compares every result with it.
// Depends on plsu_pkg.
module list_store_checker
	import plsu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_stall,
	input  plsu_req_t req,
	input  logic      rsp_valid,
	input  logic      rsp_stall,
	input  plsu_rsp_t rsp,
	output int        fail_count,
	output int        pending
);
	localparam int REPORT_MAX = 10;

	logic [31:0] list_vals [CAPACITY];
	int          list_len;
	plsu_rsp_t   due_results [$];
	int          errors;

	// Apply one request to the local list and return the result it must give.
	function automatic plsu_rsp_t list_result(input plsu_req_t r);
		plsu_rsp_t res;
		int        p;
		int        at;
		int        i;
		res        = '0;
		res.status = ST_OK;
		p          = $signed(r.position);
		case (r.req_type)
			REQ_INSERT: begin
				if (list_len >= CAPACITY) begin
					res.status = ST_FULL;
				end else if (p < -1) begin
					res.status = ST_BADPOS;
				end else begin
					at = (p == -1 || p >= list_len) ? list_len : p;
					for (i = list_len; i > at; i--)
						list_vals[i] = list_vals[i - 1];
					list_vals[at] = r.data_in;
					list_len++;
				end
			end
			REQ_REMOVE: begin
				if (list_len == 0) begin
					res.status = ST_EMPTY;
				end else if (p < -1) begin
					res.status = ST_BADPOS;
				end else begin
					at = (p == -1 || p >= list_len) ? list_len - 1 : p;
					res.data_out = list_vals[at];
					for (i = at; i + 1 < list_len; i++)
						list_vals[i] = list_vals[i + 1];
					list_len--;
				end
			end
			REQ_READ: begin
				if (list_len == 0)
					res.status = ST_EMPTY;
				else if (p == -1)
					res.data_out = list_vals[list_len - 1];
				else if (p >= 0 && p < list_len)
					res.data_out = list_vals[p];
				else
					res.status = ST_BADPOS;
			end
			default: begin
				res.status = ST_NOTFOUND;
				for (i = 0; i < list_len; i++) begin
					if (list_vals[i] == r.data_in) begin
						res.status      = ST_OK;
						res.found_index = i[5:0];
						break;
					end
				end
			end
		endcase
		res.entry_count = list_len[6:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		plsu_rsp_t want;
		if (!arst_n) begin
			list_len = 0;
			due_results.delete();
			errors = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// results leave before the request of this edge can produce one
			if (rsp_valid && !rsp_stall) begin
				if (due_results.size() == 0) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display("unexpected result: status %0d data %h index %0d count %0d",
							rsp.status, rsp.data_out, rsp.found_index, rsp.entry_count);
				end else begin
					want = due_results.pop_front();
					if (rsp.status !== want.status || rsp.data_out !== want.data_out ||
						rsp.found_index !== want.found_index ||
						rsp.entry_count !== want.entry_count) begin
						errors++;
						if (errors <= REPORT_MAX)
							$display({"mismatch: status %0d/%0d data %h/%h ",
								"index %0d/%0d count %0d/%0d (expected/actual)"},
								want.status, rsp.status, want.data_out, rsp.data_out,
								want.found_index, rsp.found_index,
								want.entry_count, rsp.entry_count);
					end
				end
			end
			if (req_valid && !req_stall)
				due_results.push_back(list_result(req));
			fail_count <= errors;
			pending <= due_results.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the positional list store unit testbench: clock, reset, request
// stimulus, result stalls and the verdict. Depends on plsu_pkg,
// positional_list_store_unit and list_store_checker.
module tb_top;
	import plsu_pkg::*;

	localparam int RANDOM_ITEMS = 1050;
	localparam int SEGMENT      = 120;      // items per fill or drain stretch
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE       = 8;        // cycles after the last result

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	plsu_req_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	plsu_rsp_t rsp;

	int fail_count;
	int pending;
	int idle_pct  = 0;
	int stall_pct = 0;
	int cycle_count = 0;

	always #6 clk = ~clk;

	positional_list_store_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	list_store_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Receiver side: stall the result channel at random, at the rate of the phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Build one request from its fields.
	function automatic plsu_req_t make_request(input plsu_req_type_t kind, input int pos,
		input logic [31:0] value);
		plsu_req_t r;
		r.req_type = kind;
		r.position = pos[7:0];
		r.data_in  = value;
		return r;
	endfunction

	// Random request. While filling, inserts dominate so the list reaches full
	// and stays there a while; while draining, removes dominate until it is empty.
	// Keys come often from a small pool so that searches hit.
	function automatic plsu_req_t random_request(input bit filling);
		plsu_req_t r;
		int        pick;
		pick = $urandom_range(0, 99);
		if (filling)
			r.req_type = (pick < 60) ? REQ_INSERT : (pick < 78) ? REQ_REMOVE :
				(pick < 89) ? REQ_READ : REQ_SEARCH;
		else
			r.req_type = (pick < 20) ? REQ_INSERT : (pick < 72) ? REQ_REMOVE :
				(pick < 86) ? REQ_READ : REQ_SEARCH;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			r.position = -8'sd1;
		else if (pick < 40)
			r.position = 8'sd0;
		else if (pick < 75)
			r.position = 8'($urandom_range(1, 66));
		else if (pick < 82)
			r.position = 8'($urandom_range(67, 127));
		else if (pick < 90)
			r.position = 8'($urandom_range(128, 254));   // -128 .. -2
		else
			r.position = 8'($urandom);
		if ($urandom_range(0, 99) < 45)
			r.data_in = 32'($urandom_range(0, 15)) - 32'd8;
		else
			r.data_in = $urandom;
		return r;
	endfunction

	// Present one request, idle first at the phase rate, and hold it until taken.
	task automatic send_request(input plsu_req_t item);
		while ($urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do
			@(posedge clk);
		while (req_stall);
	endtask

	// Drop valid and hold off until every outstanding result has come back.
	task automatic drain_results;
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	initial begin
		plsu_req_t directed [$];
		int        phase;
		int        k;
		int        issued;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: errors on an empty list, inserts at every kind of
		// position, reads at the edges and past them, searches, then remove until empty.
		directed.push_back(make_request(REQ_READ,   0,    32'd0));
		directed.push_back(make_request(REQ_REMOVE, -1,   32'd0));
		directed.push_back(make_request(REQ_SEARCH, 0,    32'd0));
		directed.push_back(make_request(REQ_INSERT, -128, 32'h1234_5678));
		directed.push_back(make_request(REQ_INSERT, 127,  32'h7FFF_FFFF));
		directed.push_back(make_request(REQ_INSERT, 0,    32'h8000_0000));
		directed.push_back(make_request(REQ_INSERT, -1,   32'h0000_0000));
		directed.push_back(make_request(REQ_INSERT, 1,    32'hFFFF_FFFF));
		directed.push_back(make_request(REQ_INSERT, 100,  32'hAAAA_5555));
		directed.push_back(make_request(REQ_READ,   -1,   32'd0));
		directed.push_back(make_request(REQ_READ,   0,    32'd0));
		directed.push_back(make_request(REQ_READ,   2,    32'd0));
		directed.push_back(make_request(REQ_READ,   5,    32'd0));
		directed.push_back(make_request(REQ_READ,   -2,   32'd0));
		directed.push_back(make_request(REQ_READ,   127,  32'd0));
		directed.push_back(make_request(REQ_SEARCH, -128, 32'hFFFF_FFFF));
		directed.push_back(make_request(REQ_SEARCH, 3,    32'h5555_AAAA));
		directed.push_back(make_request(REQ_REMOVE, -2,   32'd0));
		directed.push_back(make_request(REQ_REMOVE, 1,    32'd0));
		directed.push_back(make_request(REQ_REMOVE, 0,    32'd0));
		directed.push_back(make_request(REQ_REMOVE, -1,   32'd0));
		directed.push_back(make_request(REQ_REMOVE, 100,  32'd0));
		directed.push_back(make_request(REQ_REMOVE, 0,    32'd0));
		directed.push_back(make_request(REQ_REMOVE, 0,    32'd0));
		foreach (directed[i])
			send_request(directed[i]);

		// Pause the sender until the pipe is empty before going random.
		drain_results();

		// Three phases: sender idles lightly while the receiver stalls hard,
		// then the reverse, then full rate on both sides.
		issued = 0;
		for (phase = 0; phase < 3; phase++) begin
			idle_pct  = (phase == 0) ? 18 : (phase == 1) ? 65 : 0;
			stall_pct = (phase == 0) ? 65 : (phase == 1) ? 18 : 0;
			for (k = 0; k < RANDOM_ITEMS / 3; k++) begin
				send_request(random_request(((issued / SEGMENT) % 2) == 0));
				issued++;
			end
		end

		drain_results();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== positional_list_store_unit.f =====
rtl/plsu_pkg.sv
rtl/plsu_cell.sv
rtl/plsu_reduce.sv
rtl/positional_list_store_unit.sv
tb/list_store_checker.sv
tb/tb_top.sv
